@@ hw/rtl/bounded_waiting_lock_handoff_macros.svh @@
// Assertion macros shared by the lock handoff RTL.
// Included by the controller and datapath modules; depends on nothing else.
`ifndef BOUNDED_WAITING_LOCK_HANDOFF_MACROS_SVH
`define BOUNDED_WAITING_LOCK_HANDOFF_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BWLH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BWLH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bwlh_pkg.sv @@
// Shared types and constants for the bounded waiting lock handoff block.
// No dependencies; used by the controller, datapath and top level.
package bwlh_pkg;

  localparam int MAX_REQ_DEFAULT = 16;
  localparam int ID_W  = 4;
  localparam int CFG_W = 5;
  // Wide enough to hold any requester count up to the largest supported size.
  localparam int CNT_W = 7;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan_init;
    logic scan_step;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_end;
  } dp_stat_t;

endpackage

@@ hw/rtl/bwlh_ctrl.sv @@
// Sequencing state machine for the lock handoff block.
// Depends on bwlh_pkg and the assertion macro header.
`include "bounded_waiting_lock_handoff_macros.svh"

module bwlh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bwlh_pkg::dp_stat_t stat,
  output bwlh_pkg::dp_cmd_t  cmd
);
  import bwlh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.need_scan) begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end else begin
          cmd.eval   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BWLH_ASSERT_NEXT(a_accept_to_eval, clk, rst, start && !busy, state == ST_EVAL,
                    "accepted request did not enter evaluation")
  `BWLH_ASSERT_NEXT(a_scan_holds, clk, rst, state == ST_SCAN && !stat.scan_end,
                    state == ST_SCAN, "scan ended without a result")
  `BWLH_ASSERT_NEXT(a_scan_exits, clk, rst, state == ST_SCAN && stat.scan_end,
                    state == ST_IDLE, "scan did not return to idle")

endmodule

@@ hw/rtl/bwlh_dp.sv @@
// Datapath for the lock handoff block: waiting bits, lock flag, scan pointer
// and result registers. Depends on bwlh_pkg and the assertion macro header.
`include "bounded_waiting_lock_handoff_macros.svh"

module bwlh_dp #(
  parameter int MAX_REQUESTERS = bwlh_pkg::MAX_REQ_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bwlh_pkg::dp_cmd_t         cmd,
  output bwlh_pkg::dp_stat_t        stat,
  input  logic                      cfg_we,
  input  logic [bwlh_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      opcode,
  input  logic [bwlh_pkg::ID_W-1:0] requester_id,
  output logic                      done,
  output logic                      grant_valid,
  output logic [bwlh_pkg::ID_W-1:0] grant_id,
  output logic                      lock_busy,
  output logic                      error
);
  import bwlh_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTERS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTERS);

  logic [CFG_W-1:0]        active;
  logic [MAX_REQUESTERS-1:0] waiting;
  logic                    held;
  logic                    op_r;
  logic [ID_W-1:0]         id_r;
  logic [IDX_W-1:0]        ptr;

  logic [CNT_W-1:0] active_ext;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] id_ext;
  logic [CNT_W-1:0] ptr_ext;
  logic [CNT_W-1:0] id_inc;
  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] id_idx;
  logic             in_range;
  logic             at_self;

  // Saturate the configured count to 1..MAX_REQUESTERS.
  assign active_ext = CNT_W'(active);
  always_comb begin
    if (active_ext == '0) begin
      count = CNT_W'(1);
    end else if (active_ext > MAX_CNT) begin
      count = MAX_CNT;
    end else begin
      count = active_ext;
    end
  end

  assign id_ext   = CNT_W'(id_r);
  assign ptr_ext  = CNT_W'(ptr);
  assign id_idx   = IDX_W'(id_r);
  assign in_range = (id_ext < count);
  assign id_inc   = id_ext + CNT_W'(1);
  assign ptr_inc  = ptr_ext + CNT_W'(1);
  assign at_self  = (ptr_ext == id_ext);

  assign stat.need_scan = in_range && (op_r == OP_RELEASE) && held;
  assign stat.scan_end  = at_self || waiting[ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= ACTIVE_RESET;
      waiting <= '0;
      held    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        active <= cfg_wdata;
      end
      if (cmd.eval) begin
        done <= 1'b1;
        if (in_range && op_r == OP_ACQUIRE) begin
          if (!held) begin
            held <= 1'b1;
          end else begin
            waiting[id_idx] <= 1'b1;
          end
        end
      end
      if (cmd.scan_step) begin
        if (at_self) begin
          // Nobody else is waiting: the lock becomes free.
          held <= 1'b0;
          done <= 1'b1;
        end else if (waiting[ptr]) begin
          waiting[ptr] <= 1'b0;
          done         <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      id_r <= requester_id;
    end
    if (cmd.scan_init) begin
      ptr <= (id_inc == count) ? '0 : IDX_W'(id_inc);
    end else if (cmd.scan_step) begin
      ptr <= (ptr_inc == count) ? '0 : IDX_W'(ptr_inc);
    end
    if (cmd.eval) begin
      grant_valid <= 1'b0;
      grant_id    <= '0;
      error       <= 1'b0;
      lock_busy   <= held;
      if (!in_range) begin
        error <= 1'b1;
      end else if (op_r == OP_ACQUIRE) begin
        lock_busy <= 1'b1;
        if (!held) begin
          grant_valid <= 1'b1;
          grant_id    <= id_r;
        end
      end else begin
        // Release while the lock is free.
        error <= 1'b1;
      end
    end
    if (cmd.scan_step) begin
      grant_valid <= 1'b0;
      grant_id    <= '0;
      error       <= 1'b0;
      lock_busy   <= 1'b0;
      if (!at_self && waiting[ptr]) begin
        grant_valid <= 1'b1;
        grant_id    <= ID_W'(ptr);
        lock_busy   <= 1'b1;
      end
    end
  end

  `BWLH_ASSERT_IMP(a_grant_no_error, clk, rst, done && grant_valid, !error,
                   "grant reported together with an error")
  `BWLH_ASSERT_IMP(a_grant_busy, clk, rst, done && grant_valid, lock_busy && held,
                   "grant reported while the lock is free")
  `BWLH_ASSERT_NEXT(a_scan_end_done, clk, rst, cmd.scan_step && stat.scan_end, done,
                    "finished scan produced no result")

endmodule

@@ hw/rtl/bounded_waiting_lock_handoff.sv @@
// Top level of the bounded waiting lock handoff block.
// Depends on bwlh_pkg, bwlh_ctrl and bwlh_dp.
//
// Usage:
//   A lock request (opcode acquire or release, plus requester_id) is taken at
//   a rising edge with start high and busy low. Exactly one result follows:
//   grant_valid, grant_id, lock_busy and error are valid for the single cycle
//   in which done is high. The receiver cannot stall; it must take the result
//   in that cycle.
//   An acquire, an out-of-range id or a release of a free lock gives its
//   result from the evaluation state. A release of a held lock walks the
//   waiting bits round robin, one requester per cycle, from the requester
//   after the releaser until it finds one waiting or reaches the releaser.
//   busy stays high until the result is registered, so a new request can be
//   taken in the cycle done is shown.
//   The active count is written through cfg_we/cfg_wdata while busy is low.
//   Reset (rst, synchronous) clears all waiting bits, frees the lock and sets
//   the active count to 16.
module bounded_waiting_lock_handoff #(
  parameter int MAX_REQUESTERS = bwlh_pkg::MAX_REQ_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bwlh_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [bwlh_pkg::ID_W-1:0]  requester_id,
  output logic                       done,
  output logic                       grant_valid,
  output logic [bwlh_pkg::ID_W-1:0]  grant_id,
  output logic                       lock_busy,
  output logic                       error
);
  import bwlh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bwlh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bwlh_dp #(
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .opcode       (opcode),
    .requester_id (requester_id),
    .done         (done),
    .grant_valid  (grant_valid),
    .grant_id     (grant_id),
    .lock_busy    (lock_busy),
    .error        (error)
  );

endmodule
